// ===== hw/rtl/pwrseq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwrseq_pkg
// Types and codes shared by the power sequencer modules.
// ----------------------------------------------------------------------------
package pwrseq_pkg;

  typedef enum logic [2:0] {
    SYS_OFF       = 3'd0,
    SYS_STARTING  = 3'd1,
    SYS_START_ERR = 3'd2,
    SYS_STARTED   = 3'd3,
    SYS_SHUTTING  = 3'd4,
    SYS_FORCED    = 3'd6
  } sys_state_t;

  typedef enum logic [2:0] {
    HOST_OFF      = 3'd0,
    HOST_BOOTING  = 3'd1,
    HOST_BOOT_ERR = 3'd2,
    HOST_BOOTED   = 3'd3,
    HOST_SHUTTING = 3'd4
  } host_state_t;

  typedef enum logic [1:0] {
    BTN_PRESSED  = 2'd0,
    BTN_RELEASED = 2'd1,
    BTN_IDLE     = 2'd2
  } btn_latch_t;

  typedef enum logic [1:0] {
    LED_RED    = 2'd0,
    LED_BLUE   = 2'd1,
    LED_ORANGE = 2'd2,
    LED_GREEN  = 2'd3
  } led_t;

  // button edge codes
  localparam logic [1:0] BEV_PRESS   = 2'd1;
  localparam logic [1:0] BEV_RELEASE = 2'd2;
  // host line edge codes
  localparam logic [1:0] HEV_BOOTED   = 2'd1;
  localparam logic [1:0] HEV_SHUTDOWN = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_BOOT_TIMEOUT     = 2'd0;
  localparam logic [1:0] CFG_SHUTDOWN_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_HOLD_TIMEOUT     = 2'd2;
  localparam logic [1:0] CFG_RESET_PULSE_LEN  = 2'd3;

  localparam logic [15:0] BOOT_TIMEOUT_RST     = 16'd5000;
  localparam logic [15:0] SHUTDOWN_TIMEOUT_RST = 16'd5000;
  localparam logic [15:0] HOLD_TIMEOUT_RST     = 16'd3000;
  localparam logic [6:0]  RESET_PULSE_LEN_RST  = 7'd100;

  typedef struct packed {
    logic [15:0] boot_timeout;
    logic [15:0] shutdown_timeout;
    logic [15:0] hold_timeout;
    logic [6:0]  reset_pulse_len;
  } cfg_t;

  typedef struct packed {
    logic [1:0] button_event;
    logic [1:0] boot_event;
    logic       reset_button;
  } tick_t;

  typedef struct packed {
    logic        relay_on;
    led_t        led_color;
    logic        reset_out;
    sys_state_t  system_state;
    host_state_t host_state;
  } result_t;

endpackage

// ===== hw/rtl/pwrseq_fsm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwrseq_fsm
// Sequencer state, elapsed counters and reset pulse; one tick per advance.
// ----------------------------------------------------------------------------
module pwrseq_fsm #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  pwrseq_pkg::tick_t tick,
  input  pwrseq_pkg::cfg_t  cfg,
  output pwrseq_pkg::result_t result
);
  import pwrseq_pkg::*;

  localparam int CMP_W = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

  sys_state_t  system_state, system_state_next;
  host_state_t host_state, host_state_next;
  btn_latch_t  button_latch, button_latch_next;
  logic        relay_reg, relay_next;
  led_t        led_reg, led_next;
  logic [TIMER_WIDTH-1:0] boot_elapsed, boot_elapsed_next;
  logic [TIMER_WIDTH-1:0] shutdown_elapsed, shutdown_elapsed_next;
  logic [TIMER_WIDTH-1:0] hold_elapsed, hold_elapsed_next;
  logic [6:0]  reset_pulse_left, reset_pulse_left_next;

  btn_latch_t  latch_ev;
  host_state_t host_ev;
  logic [TIMER_WIDTH-1:0] boot_inc, shutdown_inc, hold_inc;
  logic [6:0]  pulse_dec;
  logic        boot_expired, shutdown_expired, hold_expired;

  // apply this tick's edge events before the sequencer runs
  always_comb begin
    latch_ev = button_latch;
    if (tick.button_event == BEV_PRESS) latch_ev = BTN_PRESSED;
    else if (tick.button_event == BEV_RELEASE) latch_ev = BTN_RELEASED;
    host_ev = host_state;
    if (tick.boot_event == HEV_BOOTED) host_ev = HOST_BOOTED;
    else if (tick.boot_event == HEV_SHUTDOWN) host_ev = HOST_SHUTTING;
  end

  assign boot_inc     = (&boot_elapsed) ? boot_elapsed : boot_elapsed + TIMER_WIDTH'(1);
  assign shutdown_inc = (&shutdown_elapsed) ? shutdown_elapsed
                                            : shutdown_elapsed + TIMER_WIDTH'(1);
  assign hold_inc     = (&hold_elapsed) ? hold_elapsed : hold_elapsed + TIMER_WIDTH'(1);
  assign pulse_dec    = (reset_pulse_left != 7'd0) ? reset_pulse_left - 7'd1
                                                   : reset_pulse_left;

  assign boot_expired     = CMP_W'(boot_inc) >= CMP_W'(cfg.boot_timeout);
  assign shutdown_expired = CMP_W'(shutdown_inc) >= CMP_W'(cfg.shutdown_timeout);
  assign hold_expired     = CMP_W'(hold_inc) >= CMP_W'(cfg.hold_timeout);

  // next state
  always_comb begin
    system_state_next     = system_state;
    host_state_next       = host_ev;
    button_latch_next     = latch_ev;
    boot_elapsed_next     = boot_inc;
    shutdown_elapsed_next = shutdown_inc;
    hold_elapsed_next     = hold_inc;
    reset_pulse_left_next = pulse_dec;
    case (system_state)
      SYS_OFF: begin
        if (latch_ev == BTN_PRESSED) begin
          button_latch_next = BTN_IDLE;
          host_state_next   = HOST_OFF;
          system_state_next = SYS_STARTING;
        end
      end
      SYS_STARTING: begin
        case (host_ev)
          HOST_OFF: begin
            host_state_next   = HOST_BOOTING;
            boot_elapsed_next = '0;
          end
          HOST_BOOTING:  if (boot_expired) host_state_next = HOST_BOOT_ERR;
          HOST_BOOT_ERR: system_state_next = SYS_START_ERR;
          HOST_BOOTED:   system_state_next = SYS_STARTED;
          default: ;
        endcase
      end
      SYS_START_ERR: begin
        if (latch_ev == BTN_PRESSED) begin
          button_latch_next = BTN_IDLE;
          system_state_next = SYS_OFF;
        end
        if (host_ev == HOST_BOOTED) system_state_next = SYS_STARTED;
      end
      SYS_STARTED: begin
        if (tick.reset_button && pulse_dec == 7'd0)
          reset_pulse_left_next = cfg.reset_pulse_len;
        if (host_ev == HOST_SHUTTING) begin
          shutdown_elapsed_next = '0;
          system_state_next     = SYS_SHUTTING;
        end
        // a press overrides a shutdown seen in the same tick
        if (latch_ev == BTN_PRESSED) begin
          button_latch_next = BTN_IDLE;
          hold_elapsed_next = '0;
          system_state_next = SYS_FORCED;
        end
      end
      SYS_SHUTTING: begin
        if (host_ev == HOST_SHUTTING) begin
          if (shutdown_expired) host_state_next = HOST_OFF;
        end else if (host_ev == HOST_OFF) begin
          system_state_next = SYS_OFF;
        end
      end
      SYS_FORCED: begin
        if (latch_ev == BTN_IDLE) begin
          if (hold_expired) begin
            system_state_next = SYS_OFF;
            host_state_next   = HOST_OFF;
          end
        end else if (latch_ev == BTN_RELEASED) begin
          system_state_next = SYS_STARTED;
        end
      end
      default: ;
    endcase
  end

  // relay and indicator follow the state the tick starts in
  always_comb begin
    relay_next = relay_reg;
    led_next   = led_reg;
    case (system_state)
      SYS_OFF: begin
        relay_next = 1'b0;
        led_next   = LED_RED;
      end
      SYS_STARTING: begin
        relay_next = 1'b1;
        led_next   = LED_BLUE;
      end
      SYS_START_ERR: led_next = LED_ORANGE;
      SYS_STARTED:   led_next = LED_GREEN;
      SYS_SHUTTING:  led_next = LED_BLUE;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      system_state     <= SYS_OFF;
      host_state       <= HOST_OFF;
      button_latch     <= BTN_IDLE;
      relay_reg        <= 1'b0;
      led_reg          <= LED_RED;
      boot_elapsed     <= '0;
      shutdown_elapsed <= '0;
      hold_elapsed     <= '0;
      reset_pulse_left <= 7'd0;
    end else if (advance) begin
      system_state     <= system_state_next;
      host_state       <= host_state_next;
      button_latch     <= button_latch_next;
      relay_reg        <= relay_next;
      led_reg          <= led_next;
      boot_elapsed     <= boot_elapsed_next;
      shutdown_elapsed <= shutdown_elapsed_next;
      hold_elapsed     <= hold_elapsed_next;
      reset_pulse_left <= reset_pulse_left_next;
    end
  end

  always_comb begin
    result.relay_on     = relay_next;
    result.led_color    = led_next;
    result.reset_out    = (reset_pulse_left_next != 7'd0);
    result.system_state = system_state_next;
    result.host_state   = host_state_next;
  end

endmodule

// ===== hw/rtl/power_sequencer_with_timeouts.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// power_sequencer_with_timeouts
// Tick-driven power sequencer with boot, shutdown and hold timeouts.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_ready  | button_event, boot_event, reset_button
//  out     | out_valid / out_ready| relay_on, led_color, reset_out,
//          |                      | system_state_out, host_state_out
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item per cycle while the output is not stalled; an accepted item is held in the
// input register, and the result register is loaded when the item advances.
// The step is one pass of the sequencer logic in pwrseq_fsm.
// Reset clears the sequencer and loads default timeouts; cfg_ready is always high.
// A stalled output holds the pipeline; in_ready drops only when both stages are
// full and out_ready is low.
// ----------------------------------------------------------------------------
module power_sequencer_with_timeouts #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  button_event,
  input  logic [1:0]  boot_event,
  input  logic        reset_button,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        relay_on,
  output logic [1:0]  led_color,
  output logic        reset_out,
  output logic [2:0]  system_state_out,
  output logic [2:0]  host_state_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import pwrseq_pkg::*;

  cfg_t    cfg;
  tick_t   tick;
  logic    tick_valid;
  logic    advance;
  result_t result;
  result_t out_reg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.boot_timeout     <= BOOT_TIMEOUT_RST;
      cfg.shutdown_timeout <= SHUTDOWN_TIMEOUT_RST;
      cfg.hold_timeout     <= HOLD_TIMEOUT_RST;
      cfg.reset_pulse_len  <= RESET_PULSE_LEN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BOOT_TIMEOUT:     cfg.boot_timeout     <= cfg_data;
        CFG_SHUTDOWN_TIMEOUT: cfg.shutdown_timeout <= cfg_data;
        CFG_HOLD_TIMEOUT:     cfg.hold_timeout     <= cfg_data;
        CFG_RESET_PULSE_LEN:  cfg.reset_pulse_len  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // advance the held item into the result register when it is free
  assign advance  = tick_valid && (!out_valid || out_ready);
  assign in_ready = !tick_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (in_ready) begin
      tick_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      tick.button_event <= button_event;
      tick.boot_event   <= boot_event;
      tick.reset_button <= reset_button;
    end
  end

  pwrseq_fsm #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_fsm (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .tick    (tick),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_reg <= result;
  end

  assign relay_on         = out_reg.relay_on;
  assign led_color        = out_reg.led_color;
  assign reset_out        = out_reg.reset_out;
  assign system_state_out = out_reg.system_state;
  assign host_state_out   = out_reg.host_state;

  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> tick_valid && out_valid && !out_ready)
    else $error("input stalled with a free stage");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    tick_valid && out_valid && !out_ready |=> tick_valid && out_valid)
    else $error("item lost while output stalled");

  a_starting_blue: assert property (@(posedge clk) disable iff (rst)
    advance && result.system_state == SYS_STARTING && result.host_state == HOST_BOOTING
    |-> result.relay_on && result.led_color == LED_BLUE)
    else $error("booting without relay and blue indicator");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tick-driven power sequencer.
// Ticks are sent with random bursts and gaps while the result side stalls on
// its own pattern. A local copy of the sequencer predicts every result item,
// and each result item is compared field by field with that prediction.
// Timeout registers are swept through short, extreme and full-scale settings.
// ----------------------------------------------------------------------------
module tb;
  import pwrseq_pkg::*;

  localparam int TIMER_WIDTH = 16;
  localparam int STALL_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  button_event;
  logic [1:0]  boot_event;
  logic        reset_button;
  logic        out_valid;
  logic        out_ready;
  logic        relay_on;
  logic [1:0]  led_color;
  logic        reset_out;
  logic [2:0]  system_state_out;
  logic [2:0]  host_state_out;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  power_sequencer_with_timeouts #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .button_event     (button_event),
    .boot_event       (boot_event),
    .reset_button     (reset_button),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .relay_on         (relay_on),
    .led_color        (led_color),
    .reset_out        (reset_out),
    .system_state_out (system_state_out),
    .host_state_out   (host_state_out),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #1 clk = ~clk;

  // sequencer copy
  sys_state_t              sys_q;
  host_state_t             host_q;
  btn_latch_t              btn_q;
  logic                    relay_q;
  led_t                    led_q;
  logic [TIMER_WIDTH-1:0]  boot_cnt;
  logic [TIMER_WIDTH-1:0]  shut_cnt;
  logic [TIMER_WIDTH-1:0]  hold_cnt;
  logic [6:0]              pulse_left;
  logic [15:0]             boot_to;
  logic [15:0]             shut_to;
  logic [15:0]             hold_to;
  logic [6:0]              pulse_len;

  result_t expected_status[$];
  int      mismatch_count = 0;
  int      burst_left = 0;
  bit      sender_gaps = 1'b1;
  int      stall_cycles = 0;
  int      rx_left = 0;
  int      rx_mode = 0;

  function automatic logic [TIMER_WIDTH-1:0] sat_up(input logic [TIMER_WIDTH-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic result_t advance_sequencer(input logic [1:0] bev, input logic [1:0] hev,
                                                input logic rb);
    result_t r;
    if (bev == BEV_PRESS) btn_q = BTN_PRESSED;
    else if (bev == BEV_RELEASE) btn_q = BTN_RELEASED;
    if (hev == HEV_BOOTED) host_q = HOST_BOOTED;
    else if (hev == HEV_SHUTDOWN) host_q = HOST_SHUTTING;

    boot_cnt = sat_up(boot_cnt);
    shut_cnt = sat_up(shut_cnt);
    hold_cnt = sat_up(hold_cnt);
    if (pulse_left != 0) pulse_left = pulse_left - 1'b1;

    case (sys_q)
      SYS_OFF: begin
        led_q = LED_RED;
        relay_q = 1'b0;
        if (btn_q == BTN_PRESSED) begin
          btn_q = BTN_IDLE;
          host_q = HOST_OFF;
          sys_q = SYS_STARTING;
        end
      end
      SYS_STARTING: begin
        led_q = LED_BLUE;
        relay_q = 1'b1;
        case (host_q)
          HOST_OFF: begin
            host_q = HOST_BOOTING;
            boot_cnt = '0;
          end
          HOST_BOOTING: if (boot_cnt >= boot_to) host_q = HOST_BOOT_ERR;
          HOST_BOOT_ERR: sys_q = SYS_START_ERR;
          HOST_BOOTED: sys_q = SYS_STARTED;
          default: ;
        endcase
      end
      SYS_START_ERR: begin
        led_q = LED_ORANGE;
        if (btn_q == BTN_PRESSED) begin
          btn_q = BTN_IDLE;
          sys_q = SYS_OFF;
        end
        if (host_q == HOST_BOOTED) sys_q = SYS_STARTED;
      end
      SYS_STARTED: begin
        led_q = LED_GREEN;
        if (rb && pulse_left == 0) pulse_left = pulse_len;
        if (host_q == HOST_SHUTTING) begin
          shut_cnt = '0;
          sys_q = SYS_SHUTTING;
        end
        if (btn_q == BTN_PRESSED) begin
          btn_q = BTN_IDLE;
          hold_cnt = '0;
          sys_q = SYS_FORCED;
        end
      end
      SYS_SHUTTING: begin
        led_q = LED_BLUE;
        if (host_q == HOST_SHUTTING) begin
          if (shut_cnt >= shut_to) host_q = HOST_OFF;
        end else if (host_q == HOST_OFF) begin
          sys_q = SYS_OFF;
        end
      end
      SYS_FORCED: begin
        // relay and color hold their last values here
        if (btn_q == BTN_IDLE) begin
          if (hold_cnt >= hold_to) begin
            sys_q = SYS_OFF;
            host_q = HOST_OFF;
          end
        end else if (btn_q == BTN_RELEASED) begin
          sys_q = SYS_STARTED;
        end
      end
      default: ;
    endcase

    r.relay_on     = relay_q;
    r.led_color    = led_q;
    r.reset_out    = (pulse_left != 0);
    r.system_state = sys_q;
    r.host_state   = host_q;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] want_v,
                                 input logic [15:0] got_v);
    $display("%0t: mismatch on %s: expected %0h, got %0h", $time, what, want_v, got_v);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------- sender
  task automatic send_tick(input logic [1:0] bev, input logic [1:0] hev, input logic rb);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = 0;
      if (sender_gaps && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    button_event <= bev;
    boot_event   <= hev;
    reset_button <= rb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_status.push_back(advance_sequencer(bev, hev, rb));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_setting(input logic [1:0] idx, input logic [15:0] data);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_BOOT_TIMEOUT:     boot_to = data;
      CFG_SHUTDOWN_TIMEOUT: shut_to = data;
      CFG_HOLD_TIMEOUT:     hold_to = data;
      CFG_RESET_PULSE_LEN:  pulse_len = data[6:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [15:0] boot_v, input logic [15:0] shut_v,
                           input logic [15:0] hold_v, input logic [15:0] pulse_v);
    write_setting(CFG_BOOT_TIMEOUT, boot_v);
    write_setting(CFG_SHUTDOWN_TIMEOUT, shut_v);
    write_setting(CFG_HOLD_TIMEOUT, hold_v);
    write_setting(CFG_RESET_PULSE_LEN, pulse_v);
  endtask

  // Pick a tick that moves the current state along most of the time, with
  // some fully random noise mixed in.
  task automatic pick_tick(output logic [1:0] bev, output logic [1:0] hev, output logic rb);
    int roll;
    bev = '0;
    hev = '0;
    rb = ($urandom_range(0, 3) == 0);
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      bev = 2'($urandom_range(0, 3));
      hev = 2'($urandom_range(0, 3));
      rb  = 1'($urandom_range(0, 1));
    end else begin
      roll = $urandom_range(0, 99);
      case (sys_q)
        SYS_OFF: begin
          if (roll < 30) bev = BEV_PRESS;
          else if (roll < 36) hev = 2'($urandom_range(1, 2));
        end
        SYS_STARTING: if (roll < 15) hev = HEV_BOOTED;
        SYS_START_ERR: begin
          if (roll < 15) bev = BEV_PRESS;
          else if (roll < 30) hev = HEV_BOOTED;
        end
        SYS_STARTED: begin
          rb = 1'($urandom_range(0, 1));
          if (roll < 8) bev = BEV_PRESS;
          else if (roll < 16) hev = HEV_SHUTDOWN;
          else if (roll < 20) hev = HEV_BOOTED;
          else if (roll < 23) bev = BEV_RELEASE;
        end
        SYS_SHUTTING: begin
          if (host_q != HOST_SHUTTING && host_q != HOST_OFF && roll < 30) hev = HEV_SHUTDOWN;
          else if (roll < 4) hev = HEV_BOOTED;
        end
        SYS_FORCED: begin
          if (roll < 20) bev = BEV_RELEASE;
          else if (roll < 25) bev = BEV_PRESS;
        end
        default: ;
      endcase
    end
  endtask

  task automatic random_ticks(input int n);
    logic [1:0] bev;
    logic [1:0] hev;
    logic       rb;
    for (int i = 0; i < n; i++) begin
      pick_tick(bev, hev, rb);
      send_tick(bev, hev, rb);
    end
  endtask

  // Walk back to off; needs short timeouts.
  task automatic steer_to_off();
    while (sys_q != SYS_OFF) begin
      case (sys_q)
        SYS_START_ERR, SYS_STARTED: send_tick(BEV_PRESS, 2'd0, 1'b0);
        SYS_STARTING: begin
          // a host that signaled shutdown while starting never times out
          if (host_q == HOST_SHUTTING) send_tick(2'd0, HEV_BOOTED, 1'b0);
          else send_tick(2'd0, 2'd0, 1'b0);
        end
        SYS_FORCED: begin
          if (btn_q == BTN_IDLE) send_tick(2'd0, 2'd0, 1'b0);
          else send_tick(BEV_RELEASE, 2'd0, 1'b0);
        end
        SYS_SHUTTING: begin
          if (host_q == HOST_SHUTTING || host_q == HOST_OFF) send_tick(2'd0, 2'd0, 1'b0);
          else send_tick(2'd0, HEV_SHUTDOWN, 1'b0);
        end
        default: send_tick(2'd0, 2'd0, 1'b0);
      endcase
    end
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_default_walk();
    send_tick(2'd0, 2'd0, 1'b0);
    send_tick(2'd3, 2'd3, 1'b1);                 // unused codes, reset button while off
    send_tick(BEV_PRESS, 2'd0, 1'b0);            // off -> starting
    send_tick(2'd0, 2'd0, 1'b0);                 // host booting
    send_tick(2'd0, HEV_BOOTED, 1'b1);           // -> started
    send_tick(2'd0, 2'd0, 1'b1);                 // load reset pulse
    send_tick(2'd0, 2'd0, 1'b1);                 // reset button during pulse is ignored
    send_tick(BEV_PRESS, 2'd0, 1'b0);            // -> forced
    send_tick(BEV_PRESS, 2'd0, 1'b0);            // new press while forced
    send_tick(BEV_RELEASE, 2'd0, 1'b0);          // released -> started
    send_tick(2'd0, HEV_SHUTDOWN, 1'b0);         // -> shutting down, pulse keeps running
  endtask

  task automatic test_short_timeouts();
    write_all(16'd2, 16'd1, 16'd1, 16'd1);
    send_tick(2'd0, 2'd0, 1'b0);                 // shutdown timeout, host off
    send_tick(2'd0, 2'd0, 1'b0);                 // -> off
    send_tick(BEV_PRESS, 2'd0, 1'b0);
    send_tick(2'd0, 2'd0, 1'b0);
    send_tick(2'd0, 2'd0, 1'b0);
    send_tick(2'd0, 2'd0, 1'b0);                 // boot timeout
    send_tick(2'd0, 2'd0, 1'b0);                 // -> start error
    send_tick(2'd0, HEV_BOOTED, 1'b0);           // late boot -> started
    send_tick(BEV_PRESS, 2'd0, 1'b1);            // -> forced; earlier reset pulse still running
    send_tick(2'd0, 2'd0, 1'b1);                 // hold timeout -> off
    send_tick(BEV_PRESS, 2'd0, 1'b0);
    send_tick(2'd0, 2'd0, 1'b0);
    send_tick(2'd0, 2'd0, 1'b0);
    send_tick(2'd0, 2'd0, 1'b0);
    send_tick(2'd0, 2'd0, 1'b0);                 // start error
    send_tick(BEV_PRESS, 2'd0, 1'b0);            // press from start error -> off
  endtask

  task automatic test_random_settings();
    for (int p = 0; p < 5; p++) begin
      write_all(16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)),
                16'($urandom_range(1, 12)), 16'($urandom_range(1, 10)));
      random_ticks(180);
    end
  endtask

  task automatic test_config_extremes();
    write_all(16'd1, 16'd1, 16'd1, 16'd1);
    random_ticks(150);
    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd127);
    random_ticks(150);
  endtask

  // Let the boot timer run up to a long timeout with no sender gaps.
  task automatic test_long_boot_timeout();
    write_all(16'd1, 16'd1, 16'd1, 16'd3);
    steer_to_off();
    write_setting(CFG_BOOT_TIMEOUT, 16'd300);
    sender_gaps = 1'b0;
    send_tick(BEV_PRESS, 2'd0, 1'b0);
    while (sys_q == SYS_STARTING) send_tick(2'd0, 2'd0, 1'b0);
    send_tick(2'd0, 2'd0, 1'b0);
    sender_gaps = 1'b1;
    send_tick(BEV_PRESS, 2'd0, 1'b0);
  endtask

  // ---------------------------------------------------------------- receiver
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_left = $urandom_range(1, 40);
      rx_mode = $urandom_range(0, 2);
    end
    rx_left--;
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_status.size() == 0) begin
        report_mismatch("unexpected item", 16'd0, {13'd0, system_state_out});
      end else begin
        want = expected_status.pop_front();
        if (relay_on !== want.relay_on)
          report_mismatch("relay_on", 16'(want.relay_on), 16'(relay_on));
        if (led_color !== want.led_color)
          report_mismatch("led_color", 16'(want.led_color), 16'(led_color));
        if (reset_out !== want.reset_out)
          report_mismatch("reset_out", 16'(want.reset_out), 16'(reset_out));
        if (system_state_out !== want.system_state)
          report_mismatch("system_state_out", 16'(want.system_state),
                          16'(system_state_out));
        if (host_state_out !== want.host_state)
          report_mismatch("host_state_out", 16'(want.host_state), 16'(host_state_out));
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    button_event = '0;
    boot_event   = '0;
    reset_button = 1'b0;
    out_ready    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;

    sys_q      = SYS_OFF;
    host_q     = HOST_OFF;
    btn_q      = BTN_IDLE;
    relay_q    = 1'b0;
    led_q      = LED_RED;
    boot_cnt   = '0;
    shut_cnt   = '0;
    hold_cnt   = '0;
    pulse_left = '0;
    boot_to    = BOOT_TIMEOUT_RST;
    shut_to    = SHUTDOWN_TIMEOUT_RST;
    hold_to    = HOLD_TIMEOUT_RST;
    pulse_len  = RESET_PULSE_LEN_RST;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_default_walk();
    test_short_timeouts();
    test_random_settings();
    test_config_extremes();
    test_long_boot_timeout();

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
